### design/rdr_pkg.sv
// Shared widths, rounding mode codes and the divider stage payload for the rescaler.
package rdr_pkg;

    localparam int NUM_WIDTH  = 64;
    localparam int DEN_WIDTH  = 32;
    localparam int PROD_WIDTH = NUM_WIDTH + DEN_WIDTH;
    localparam int HALF_WIDTH = NUM_WIDTH / 2;

    typedef enum logic [2:0] {
        RM_FLOOR     = 3'd0,
        RM_CEIL      = 3'd1,
        RM_TRUNC     = 3'd2,
        RM_AWAY      = 3'd3,
        RM_HALF_DOWN = 3'd4,
        RM_HALF_UP   = 3'd5,
        RM_HALF_EVEN = 3'd6,
        RM_NEVER     = 3'd7
    } t_round_mode;

    // Payload of one restoring division step: dividend bits shift out at the top,
    // quotient bits shift in at the bottom.
    typedef struct packed {
        logic [PROD_WIDTH-1:0] dq;
        logic [DEN_WIDTH-1:0]  rem;
        logic [DEN_WIDTH-1:0]  den;
        logic                  neg;
        t_round_mode           mode;
        logic                  den_zero;
    } t_div_item;

endpackage

### design/rational_denominator_rounder_top.sv
// Top level of the rational rescaler: multiply, bit-serial pipelined divide, round, saturate.
// Registered path: capture, partial products, product sum, divider chain, rounding, output register.
// Throughput: one transaction per cycle while the skid buffer is empty; one pipelined divider stage per quotient bit.
// A one-entry skid buffer at the output lets input flow while one result waits; a full skid buffer stalls the pipeline.
// Reset (synchronous, active low) clears valid bits only, the skid buffer's valid bit among them.
// No configuration and no state carries between transactions.
module rational_denominator_rounder_top
    import rdr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] value_num, [95:64] value_den, [127:96] target_den
    input  logic [127:0] s_axis_tdata,
    // [2:0] round_mode
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] result_num
    output logic [63:0]  m_axis_tdata,
    // [0] inexact, [1] overflow
    output logic [1:0]   m_axis_tuser
);

    logic w_en;

    // Stage 0: capture and take magnitude
    logic                  r_s0_v;
    logic [NUM_WIDTH-1:0]  r_s0_mag;
    logic                  r_s0_neg;
    logic [DEN_WIDTH-1:0]  r_s0_den;
    logic [DEN_WIDTH-1:0]  r_s0_tgt;
    t_round_mode           r_s0_mode;
    logic [NUM_WIDTH-1:0]  w_num;
    logic [NUM_WIDTH-1:0]  n_s0_mag;

    // Stage 1: partial products
    logic                                  r_s1_v;
    logic [HALF_WIDTH+DEN_WIDTH-1:0]       r_s1_plo;
    logic [NUM_WIDTH-HALF_WIDTH+DEN_WIDTH-1:0] r_s1_phi;
    logic                                  r_s1_neg;
    logic [DEN_WIDTH-1:0]                  r_s1_den;
    t_round_mode                           r_s1_mode;

    // Stage 2: full product, divider entry
    logic      r_s2_v;
    t_div_item r_s2_item;
    t_div_item n_s2_item;

    // Divider chain
    logic      w_dv [0:PROD_WIDTH];
    t_div_item w_di [0:PROD_WIDTH];

    // Rounding stage
    logic                  r_rd_v;
    logic [PROD_WIDTH-1:0] r_rd_q;
    logic                  r_rd_neg;
    logic                  r_rd_inexact;
    logic                  r_rd_dz;
    logic [PROD_WIDTH-1:0] n_rd_q;
    logic                  w_up;
    logic                  w_rnz;
    logic [DEN_WIDTH:0]    w_two_r;
    logic [DEN_WIDTH:0]    w_dext;
    t_div_item             w_last;

    // Output and skid registers
    logic                  r_out_v;
    logic [NUM_WIDTH-1:0]  r_out_res;
    logic                  r_out_inexact;
    logic                  r_out_ovf;
    logic [NUM_WIDTH-1:0]  n_out_res;
    logic                  n_out_inexact;
    logic                  n_out_ovf;
    logic                  r_skid_v;
    logic [NUM_WIDTH-1:0]  r_skid_res;
    logic                  r_skid_inexact;
    logic                  r_skid_ovf;
    logic                  w_big;
    logic [NUM_WIDTH-1:0]  w_sat;
    logic [NUM_WIDTH-1:0]  w_qlo;
    logic [NUM_WIDTH-1:0]  w_res;

    // Advance the whole pipeline while the skid buffer is free
    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;

    assign w_num    = s_axis_tdata[NUM_WIDTH-1:0];
    assign n_s0_mag = s_axis_tdata[NUM_WIDTH-1] ? (~w_num + 1'b1) : w_num;

    // Valid bits of the front stages and the rounding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_rd_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v <= s_axis_tvalid;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
            r_rd_v <= w_dv[PROD_WIDTH];
        end
    end

    // Front payload: magnitude, partial products, product sum
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_mag  <= n_s0_mag;
            r_s0_neg  <= s_axis_tdata[NUM_WIDTH-1];
            r_s0_den  <= s_axis_tdata[64 +: DEN_WIDTH];
            r_s0_tgt  <= s_axis_tdata[96 +: DEN_WIDTH];
            r_s0_mode <= t_round_mode'(s_axis_tuser);

            r_s1_plo  <= r_s0_mag[HALF_WIDTH-1:0] * r_s0_tgt;
            r_s1_phi  <= r_s0_mag[NUM_WIDTH-1:HALF_WIDTH] * r_s0_tgt;
            r_s1_neg  <= r_s0_neg;
            r_s1_den  <= r_s0_den;
            r_s1_mode <= r_s0_mode;

            r_s2_item <= n_s2_item;
        end
    end

    always_comb begin
        n_s2_item.dq       = PROD_WIDTH'(r_s1_plo) + (PROD_WIDTH'(r_s1_phi) << HALF_WIDTH);
        n_s2_item.rem      = '0;
        n_s2_item.den      = r_s1_den;
        n_s2_item.neg      = r_s1_neg;
        n_s2_item.mode     = r_s1_mode;
        n_s2_item.den_zero = (r_s1_den == '0);
    end

    // Divide: one quotient bit per stage
    assign w_dv[0] = r_s2_v;
    assign w_di[0] = r_s2_item;

    for (genvar g = 0; g < PROD_WIDTH; g++) begin : g_div
        rdr_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[g]),
            .i_item  (w_di[g]),
            .o_valid (w_dv[g+1]),
            .o_item  (w_di[g+1])
        );
    end

    // Round the quotient by the remainder
    assign w_last  = w_di[PROD_WIDTH];
    assign w_rnz   = (w_last.rem != '0);
    assign w_two_r = {w_last.rem, 1'b0};
    assign w_dext  = {1'b0, w_last.den};

    always_comb begin
        w_up = 1'b0;
        case (w_last.mode)
            RM_FLOOR:     w_up = w_last.neg;
            RM_CEIL:      w_up = !w_last.neg;
            RM_TRUNC:     w_up = 1'b0;
            RM_AWAY:      w_up = 1'b1;
            RM_HALF_DOWN: w_up = (w_two_r > w_dext);
            RM_HALF_UP:   w_up = (w_two_r >= w_dext);
            RM_HALF_EVEN: w_up = (w_two_r > w_dext) || ((w_two_r == w_dext) && w_last.dq[0]);
            RM_NEVER:     w_up = 1'b0;
            default:      w_up = 1'b0;
        endcase
        n_rd_q = w_last.dq + PROD_WIDTH'(w_rnz && w_up);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rd_q       <= n_rd_q;
            r_rd_neg     <= w_last.neg;
            r_rd_inexact <= w_rnz;
            r_rd_dz      <= w_last.den_zero;
        end
    end

    // Saturate and apply the sign
    assign w_qlo = r_rd_q[NUM_WIDTH-1:0];
    always_comb begin
        if (r_rd_neg) begin
            w_big = (r_rd_q[PROD_WIDTH-1:NUM_WIDTH] != '0) ||
                    (r_rd_q[NUM_WIDTH-1] && (r_rd_q[NUM_WIDTH-2:0] != '0));
            w_sat = {1'b1, {(NUM_WIDTH-1){1'b0}}};
            w_res = ~w_qlo + 1'b1;
        end else begin
            w_big = (r_rd_q[PROD_WIDTH-1:NUM_WIDTH-1] != '0);
            w_sat = {1'b0, {(NUM_WIDTH-1){1'b1}}};
            w_res = w_qlo;
        end
        if (r_rd_dz) begin
            n_out_res     = '0;
            n_out_inexact = 1'b0;
            n_out_ovf     = 1'b1;
        end else begin
            n_out_res     = w_big ? w_sat : w_res;
            n_out_inexact = r_rd_inexact;
            n_out_ovf     = w_big;
        end
    end

    // Output register and skid valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_out_v <= r_rd_v;
            end
            if (w_en && r_out_v && !m_axis_tready) begin
                r_skid_v <= 1'b1;
            end else if (r_skid_v && m_axis_tready) begin
                r_skid_v <= 1'b0;
            end
        end
    end

    // Load the output register; hold a waiting result in the skid buffer when the output register moves on
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_res     <= n_out_res;
            r_out_inexact <= n_out_inexact;
            r_out_ovf     <= n_out_ovf;
        end
        if (w_en && r_out_v && !m_axis_tready) begin
            r_skid_res     <= r_out_res;
            r_skid_inexact <= r_out_inexact;
            r_skid_ovf     <= r_out_ovf;
        end
    end

    assign m_axis_tvalid = r_skid_v | r_out_v;
    assign m_axis_tdata  = r_skid_v ? 64'($signed(r_skid_res)) : 64'($signed(r_out_res));
    assign m_axis_tuser  = r_skid_v ? {r_skid_ovf, r_skid_inexact} : {r_out_ovf, r_out_inexact};

endmodule

### design/rdr_div_stage.sv
// One registered restoring division step: produces one quotient bit.
module rdr_div_stage
    import rdr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_div_item i_item,
    output logic      o_valid,
    output t_div_item o_item
);

    logic              r_valid;
    t_div_item         r_item;
    t_div_item         n_item;
    logic [DEN_WIDTH:0] w_shift;
    logic [DEN_WIDTH:0] w_diff;
    logic               w_ge;

    // Shift in the next dividend bit, trial subtract the divisor
    always_comb begin
        w_shift = {i_item.rem, i_item.dq[PROD_WIDTH-1]};
        w_diff  = w_shift - {1'b0, i_item.den};
        w_ge    = (w_shift >= {1'b0, i_item.den});
        n_item  = i_item;
        n_item.rem = w_ge ? w_diff[DEN_WIDTH-1:0] : w_shift[DEN_WIDTH-1:0];
        n_item.dq  = {i_item.dq[PROD_WIDTH-2:0], w_ge};
    end

    // Advance valid with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
